>>> rtl/core/gmr_pkg.sv
// ----------------------------------------------------------------------------
// gmr_pkg: shared types and constants of the generalized Mersenne reducer
// Opcodes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package gmr_pkg;

   localparam int OP_BITS    = 3;
   localparam int SLOT_BITS  = 8;
   localparam int WORD_BITS  = 32;
   localparam int ENTRY_BITS = 5;
   localparam int CNT_BITS   = 5;
   localparam int ROWS_BITS  = 7;
   localparam int POS_BITS   = 4;
   localparam int CSR_IDX_BITS = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_MOD    = 3'd0,
      OP_SQR    = 3'd1,
      OP_INDEX  = 3'd2,
      OP_OPND   = 3'd3,
      OP_REDUCE = 3'd4
   } op_type;

   localparam logic [CSR_IDX_BITS-1:0] REG_DIGIT_COUNT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_ADD_ROWS    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SUB_ROWS    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CMP,    // compare operand to square, top digit down
      ST_INIT,   // copy low operand digits into the accumulator
      ST_MULM,   // add sub_rows * m
      ST_ROWIDX, // fetch index entry of a row digit
      ST_ROWOP,  // fetch operand digit named by the entry
      ST_ROWACC, // add or subtract into accumulator digit
      ST_TOPFIX, // subtract top * m
      ST_TRIAL,  // trial subtract of m, track borrow
      ST_EMIT    // emit result digits
   } state_type;

endpackage

>>> rtl/core/gmr_if.sv
// ----------------------------------------------------------------------------
// gmr_if: valid/ready channel carrying a generic payload
// Used for request, response and register write channels.
// ----------------------------------------------------------------------------
interface gmr_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/gmr_ram.sv
// ----------------------------------------------------------------------------
// gmr_ram: one-write one-read synchronous memory
// Read data is registered; it appears in the cycle after the read address.
// ----------------------------------------------------------------------------
module gmr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/generalized_mersenne_reduction.sv
// ----------------------------------------------------------------------------
// generalized_mersenne_reduction: Solinas-style modular reduction engine
// ----------------------------------------------------------------------------
// Requests on req_ carry op/slot/word. Ops 0..3 load modulus, square, index
// and operand stores and give no response. Op 4 reduces
// the loaded 2d-digit operand modulo m and returns d response items on rsp_
// (least significant digit first, last on the top digit), or a single item
// with status 1 when the operand is not below the square.
// A reduce runs these passes in order: compare (top digit down, stopping
// early at the first differing digit), copy, sub_rows * m (only when
// sub_rows is nonzero), one pass per row with rows = add_rows + sub_rows,
// top fix, trial and emit. Every pass after the compare walks the
// accumulator memory one digit at a time; each row digit costs an index
// read, an operand read and a read-modify-write of the accumulator.
// Register writes on csr_ are taken at any time and are meant to be done
// while idle. Reset is synchronous: it returns the sequencer to idle and
// restores digit_count 8, add_rows 0, sub_rows 0; store contents are kept.
// The response sits in an output register; a stalled receiver holds the
// sequencer in place until the digit is taken.
// ----------------------------------------------------------------------------
module generalized_mersenne_reduction #(
   parameter int DIGIT_BITS  = 32,
   parameter int MAX_DIGITS  = 16,
   parameter int INDEX_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [gmr_pkg::OP_BITS-1:0]   req_op,
   input  logic [gmr_pkg::SLOT_BITS-1:0] req_slot,
   input  logic [gmr_pkg::WORD_BITS-1:0] req_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [gmr_pkg::WORD_BITS-1:0] rsp_result_digit,
   output logic [gmr_pkg::POS_BITS-1:0]  rsp_digit_position,
   output logic        rsp_status,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [gmr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [gmr_pkg::WORD_BITS-1:0]    csr_data
);
   import gmr_pkg::*;

   localparam int DB   = DIGIT_BITS;
   localparam int SQD  = 2 * MAX_DIGITS;
   localparam int ACCD = MAX_DIGITS + 1;
   localparam int MAW  = $clog2(MAX_DIGITS);
   localparam int SAW  = $clog2(SQD);
   localparam int AAW  = $clog2(ACCD);
   localparam int IAW  = $clog2(INDEX_DEPTH);
   localparam int DW   = $clog2(SQD + 1);   // counts up to 2d
   localparam int PW   = 16;                // row*d+j position width
   localparam int RW   = ROWS_BITS + 1;

   logic [CNT_BITS-1:0]  digit_count_ff;
   logic [ROWS_BITS-1:0] add_rows_ff, sub_rows_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= CNT_BITS'(8);
         add_rows_ff    <= '0;
         sub_rows_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_DIGIT_COUNT: digit_count_ff <= csr_data[CNT_BITS-1:0];
            REG_ADD_ROWS:    add_rows_ff    <= csr_data[ROWS_BITS-1:0];
            REG_SUB_ROWS:    sub_rows_ff    <= csr_data[ROWS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // saturated digit count
   logic [DW-1:0] d;
   always_comb begin
      if (digit_count_ff < CNT_BITS'(3)) d = DW'(3);
      else if (32'(digit_count_ff) > MAX_DIGITS) d = DW'(MAX_DIGITS);
      else d = DW'(digit_count_ff);
   end

   // memories
   logic           mod_we, sq_we, ix_we, op_we, acc_we;
   logic [MAW-1:0] mod_wa, mod_ra;
   logic [SAW-1:0] sq_wa, sq_ra, op_wa, op_ra;
   logic [IAW-1:0] ix_wa, ix_ra;
   logic [AAW-1:0] acc_wa, acc_ra;
   logic [DB-1:0]  mod_rd, sq_rd, op_rd, acc_rd, acc_wd;
   logic [ENTRY_BITS-1:0] ix_rd;

   gmr_ram #(.WIDTH(DB), .DEPTH(MAX_DIGITS)) u_mod (
      .clock, .wr_en(mod_we), .wr_addr(mod_wa), .wr_data(DB'(req_word)),
      .rd_addr(mod_ra), .rd_data(mod_rd));
   gmr_ram #(.WIDTH(DB), .DEPTH(SQD)) u_sq (
      .clock, .wr_en(sq_we), .wr_addr(sq_wa), .wr_data(DB'(req_word)),
      .rd_addr(sq_ra), .rd_data(sq_rd));
   gmr_ram #(.WIDTH(ENTRY_BITS), .DEPTH(INDEX_DEPTH)) u_ix (
      .clock, .wr_en(ix_we), .wr_addr(ix_wa), .wr_data(req_word[ENTRY_BITS-1:0]),
      .rd_addr(ix_ra), .rd_data(ix_rd));
   gmr_ram #(.WIDTH(DB), .DEPTH(SQD)) u_op (
      .clock, .wr_en(op_we), .wr_addr(op_wa), .wr_data(DB'(req_word)),
      .rd_addr(op_ra), .rd_data(op_rd));
   gmr_ram #(.WIDTH(DB), .DEPTH(ACCD)) u_acc (
      .clock, .wr_en(acc_we), .wr_addr(acc_wa), .wr_data(acc_wd),
      .rd_addr(acc_ra), .rd_data(acc_rd));

   // sequencer registers
   state_type      state_ff, state_in;
   logic [DW-1:0]  i_ff, i_in;          // digit counter
   logic [RW-1:0]  row_ff, row_in;
   logic [PW-1:0]  pos_ff, pos_in;      // row*d + j
   logic           c_ff, c_in;          // carry / borrow
   logic [DB-1:0]  mhi_ff, mhi_in;      // multiply carry digit
   logic [DB-1:0]  k_ff, k_in;          // multiplier
   logic [DB-1:0]  prod_lo_ff, prod_lo_in;
   logic [DB-1:0]  prod_hi_ff, prod_hi_in;
   logic [1:0]     ph_ff, ph_in;        // sub-phase within a digit

   logic             out_v_ff, out_v_in;
   logic [DB-1:0]    out_d_ff, out_d_in;
   logic [POS_BITS-1:0] out_p_ff, out_p_in;
   logic             out_s_ff, out_s_in, out_l_ff, out_l_in;

   logic out_free;
   assign out_free = !out_v_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // loads
   always_comb begin
      mod_we = req_fire && (req_op == OP_MOD) && (32'(req_slot) < MAX_DIGITS);
      sq_we  = req_fire && (req_op == OP_SQR) && (32'(req_slot) < SQD);
      op_we  = req_fire && (req_op == OP_OPND) && (32'(req_slot) < SQD);
      ix_we  = req_fire && (req_op == OP_INDEX) && (32'(req_slot) < INDEX_DEPTH);
      mod_wa = req_slot[MAW-1:0];
      sq_wa  = req_slot[SAW-1:0];
      op_wa  = req_slot[SAW-1:0];
      ix_wa  = IAW'(req_slot);
   end

   logic [DB:0]    sum;
   logic [2*DB-1:0] prod;
   logic [DB:0]    addc;
   logic [DB-1:0]  ent_dig;
   logic [RW-1:0]  rows_total;

   assign prod = mod_rd * k_ff;   // registered into prod_*_ff before use
   assign rows_total = RW'(add_rows_ff) + RW'(sub_rows_ff);

   always_comb begin
      state_in = state_ff; i_in = i_ff; row_in = row_ff;
      pos_in = pos_ff; c_in = c_ff; mhi_in = mhi_ff; k_in = k_ff;
      prod_lo_in = prod_lo_ff; prod_hi_in = prod_hi_ff; ph_in = ph_ff;
      out_v_in = out_v_ff && !rsp_ready; out_d_in = out_d_ff; out_p_in = out_p_ff;
      out_s_in = out_s_ff; out_l_in = out_l_ff;
      mod_ra = '0; sq_ra = '0; op_ra = '0; ix_ra = '0; acc_ra = '0;
      acc_we = 1'b0; acc_wa = '0; acc_wd = '0;
      sum = '0; addc = '0; ent_dig = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_op == OP_REDUCE) begin
               state_in = ST_CMP; i_in = d + d; ph_in = 2'd0;
            end
         end
         ST_CMP: begin
            // ph 0: issue read of digit i-1; ph 1: compare
            if (ph_ff == 2'd0) begin
               sq_ra = SAW'(i_ff - 1'b1); op_ra = SAW'(i_ff - 1'b1);
               ph_in = 2'd1;
            end else begin
               ph_in = 2'd0;
               i_in = i_ff - 1'b1;
               if (op_rd != sq_rd || i_ff == DW'(1)) begin
                  if (op_rd < sq_rd) begin
                     state_in = ST_INIT; i_in = '0;
                  end else if (out_free) begin
                     out_v_in = 1'b1; out_d_in = '0; out_p_in = '0;
                     out_s_in = 1'b1; out_l_in = 1'b1; state_in = ST_IDLE;
                  end else begin
                     i_in = i_ff; ph_in = 2'd1;   // hold until output is free
                     sq_ra = SAW'(i_ff - 1'b1); op_ra = SAW'(i_ff - 1'b1);
                  end
               end
            end
         end
         ST_INIT: begin
            // copy operand digit i, and zero the top digit at i==d
            if (ph_ff == 2'd0) begin
               op_ra = SAW'(i_ff); ph_in = 2'd1;
            end else begin
               acc_we = 1'b1; acc_wa = AAW'(i_ff);
               acc_wd = (i_ff == d) ? '0 : op_rd;
               ph_in = 2'd0;
               if (i_ff == d) begin
                  i_in = '0; c_in = 1'b0; mhi_in = '0;
                  if (sub_rows_ff != '0) begin
                     state_in = ST_MULM; k_in = DB'(sub_rows_ff);
                  end else begin
                     row_in = '0; pos_in = '0;
                     state_in = (rows_total != '0) ? ST_ROWIDX : ST_TOPFIX;
                     if (rows_total == '0) begin
                        acc_ra = AAW'(d); ph_in = 2'd0;
                     end
                  end
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         ST_MULM, ST_TOPFIX: begin
            // ph 0: read m[i], acc[i] (and acc[d] at first for TOPFIX)
            // ph 1: register product; ph 2: add/sub into acc, write back
            if (ph_ff == 2'd0) begin
               mod_ra = MAW'(i_ff); acc_ra = AAW'(i_ff);
               if (state_ff == ST_TOPFIX && i_ff == '0) begin
                  acc_ra = AAW'(d); ph_in = 2'd3;
               end else begin
                  ph_in = 2'd1;
               end
            end else if (ph_ff == 2'd3) begin
               k_in = acc_rd;
               ph_in = 2'd1; mod_ra = MAW'(i_ff); acc_ra = AAW'(i_ff);
            end else if (ph_ff == 2'd1) begin
               mod_ra = MAW'(i_ff); acc_ra = AAW'(i_ff);
               prod_lo_in = (i_ff == d) ? '0 : prod[DB-1:0];
               prod_hi_in = (i_ff == d) ? '0 : prod[2*DB-1:DB];
               ph_in = 2'd2;
            end else begin
               acc_ra = AAW'(i_ff);
               addc = {1'b0, prod_lo_ff} + {1'b0, mhi_ff};
               if (state_ff == ST_MULM) begin
                  sum = {1'b0, acc_rd} + {1'b0, addc[DB-1:0]} + (DB+1)'(c_ff);
                  c_in = sum[DB];
               end else begin
                  sum = {1'b0, acc_rd} - {1'b0, addc[DB-1:0]} - (DB+1)'(c_ff);
                  c_in = sum[DB];
               end
               mhi_in = prod_hi_ff + DB'(addc[DB]);
               acc_we = 1'b1; acc_wa = AAW'(i_ff);
               acc_wd = (state_ff == ST_TOPFIX && i_ff == d) ? '0 : sum[DB-1:0];
               ph_in = 2'd0;
               if (i_ff == d) begin
                  i_in = '0; c_in = 1'b0;
                  if (state_ff == ST_MULM) begin
                     row_in = '0; pos_in = '0;
                     state_in = (rows_total != '0) ? ST_ROWIDX : ST_TOPFIX;
                     mhi_in = '0;
                  end else begin
                     state_in = ST_TRIAL;
                  end
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         ST_ROWIDX: begin
            // index read for position pos (entry 0 beyond the table)
            ix_ra = IAW'(pos_ff); state_in = ST_ROWOP;
            if (i_ff == d) state_in = ST_ROWACC;
            acc_ra = AAW'(i_ff);
         end
         ST_ROWOP: begin
            ent_dig = '0;
            op_ra = SAW'(ix_rd);
            ph_in = (32'(pos_ff) < INDEX_DEPTH && DW'(ix_rd) >= d
                     && DW'(ix_rd) < d + d) ? 2'd1 : 2'd0;
            acc_ra = AAW'(i_ff);
            state_in = ST_ROWACC;
         end
         ST_ROWACC: begin
            ent_dig = (i_ff != d && ph_ff == 2'd1) ? op_rd : '0;
            if (row_ff < RW'(add_rows_ff)) begin
               sum = {1'b0, acc_rd} + {1'b0, ent_dig} + (DB+1)'(c_ff);
            end else begin
               sum = {1'b0, acc_rd} - {1'b0, ent_dig} - (DB+1)'(c_ff);
            end
            c_in = sum[DB];
            acc_we = 1'b1; acc_wa = AAW'(i_ff); acc_wd = sum[DB-1:0];
            ph_in = 2'd0;
            if (i_ff == d) begin
               i_in = '0; c_in = 1'b0; row_in = row_ff + 1'b1;
               if (row_ff + 1'b1 == rows_total) begin
                  state_in = ST_TOPFIX; mhi_in = '0;
               end else begin
                  state_in = ST_ROWIDX;
               end
            end else begin
               i_in = i_ff + 1'b1; pos_in = pos_ff + 1'b1;
               state_in = ST_ROWIDX;
            end
         end
         ST_TRIAL: begin
            // walk digits: borrow of acc - m over d digits
            if (ph_ff == 2'd0) begin
               mod_ra = MAW'(i_ff); acc_ra = AAW'(i_ff); ph_in = 2'd1;
            end else begin
               sum = {1'b0, acc_rd} - {1'b0, mod_rd} - (DB+1)'(c_ff);
               c_in = sum[DB]; ph_in = 2'd0;
               if (i_ff == d - 1'b1) begin
                  i_in = '0; state_in = ST_EMIT;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            // c_ff: borrow of trial; recompute digit with running borrow in k_ff[0]
            if (ph_ff == 2'd0) begin
               mod_ra = MAW'(i_ff); acc_ra = AAW'(i_ff); ph_in = 2'd1;
               if (i_ff == '0) k_in = '0;
            end else begin
               mod_ra = MAW'(i_ff); acc_ra = AAW'(i_ff);
               sum = {1'b0, acc_rd} - {1'b0, mod_rd} - (DB+1)'(k_ff[0]);
               if (out_free) begin
                  out_v_in = 1'b1;
                  out_d_in = c_ff ? acc_rd : sum[DB-1:0];
                  out_p_in = POS_BITS'(i_ff);
                  out_s_in = 1'b0;
                  out_l_in = (i_ff == d - 1'b1);
                  acc_we = 1'b1; acc_wa = AAW'(i_ff);
                  acc_wd = c_ff ? acc_rd : sum[DB-1:0];
                  k_in = DB'(sum[DB]);
                  ph_in = 2'd0;
                  if (i_ff == d - 1'b1) state_in = ST_IDLE;
                  else i_in = i_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         ph_ff    <= '0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         ph_ff    <= ph_in;
      end
      i_ff <= i_in; row_ff <= row_in; pos_ff <= pos_in;
      c_ff <= c_in; mhi_ff <= mhi_in; k_ff <= k_in;
      prod_lo_ff <= prod_lo_in; prod_hi_ff <= prod_hi_in;
      out_d_ff <= out_d_in; out_p_ff <= out_p_in;
      out_s_ff <= out_s_in; out_l_ff <= out_l_in;
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_result_digit   = WORD_BITS'(out_d_ff);
   assign rsp_digit_position = out_p_ff;
   assign rsp_status         = out_s_ff;
   assign rsp_last           = out_l_ff;
endmodule

>>> rtl/core/gmr_checker.sv
// ----------------------------------------------------------------------------
// gmr_checker: port-level checks of the reducer
// Response ordering and handshake rules seen at the top level.
// ----------------------------------------------------------------------------
module gmr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_status,
   input logic rsp_last,
   input logic [3:0] rsp_digit_position
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last && rsp_digit_position == 4'd0)
      else $error("error response not single");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken mid-result");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_status, rsp_last, rsp_digit_position}))
      else $error("response changed while stalled");
endmodule

bind generalized_mersenne_reduction gmr_checker u_gmr_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_status, .rsp_last, .rsp_digit_position);

>>> dv/gmr_tb_pkg.sv
// ----------------------------------------------------------------------------
// gmr_tb_pkg: payload types of the reducer testbench channels
// Request, response and register write items as carried by gmr_if.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gmr_tb_pkg;
   import gmr_pkg::*;

   typedef struct packed {
      op_type                op;
      logic [SLOT_BITS-1:0]  slot;
      logic [WORD_BITS-1:0]  word;
   } req_item_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] digit;
      logic [POS_BITS-1:0]  pos;
      logic                 status;
      logic                 last;
   } rsp_item_type;

   typedef struct packed {
      logic [CSR_IDX_BITS-1:0] index;
      logic [WORD_BITS-1:0]    value;
   } csr_item_type;

   localparam int MAX_D     = 16;
   localparam int SQ_D      = 2 * MAX_D;
   localparam int IDX_D     = 256;
   localparam int D_LOW     = 3;
   localparam int FIRST_BAD_OP = 5;
   localparam int LAST_BAD_OP  = 7;

endpackage

>>> dv/gmr_scoreboard.sv
// ----------------------------------------------------------------------------
// gmr_scoreboard: residue predictor and response checker
// Mirrors the stores and registers from accepted requests and register
// writes, computes the expected residue digits of each reduce and compares
// every accepted response with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gmr_scoreboard (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  gmr_tb_pkg::req_item_type   req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  gmr_tb_pkg::rsp_item_type   rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  gmr_tb_pkg::csr_item_type   csr_data,
   output int                         fail_count,
   output int                         pending
);
   import gmr_pkg::*;
   import gmr_tb_pkg::*;

   typedef logic [WORD_BITS-1:0] wide_digits_type [MAX_D+1];

   logic [WORD_BITS-1:0]  modulus_q [MAX_D];
   logic [WORD_BITS-1:0]  square_q  [SQ_D];
   logic [WORD_BITS-1:0]  operand_q [SQ_D];
   logic [ENTRY_BITS-1:0] index_q   [IDX_D];
   wide_digits_type       acc;
   logic [CNT_BITS-1:0]   digit_count;
   logic [ROWS_BITS-1:0]  add_rows, sub_rows;
   rsp_item_type          expected_digits [$];

   function automatic wide_digits_type modulus_times(int d, logic [WORD_BITS-1:0] k);
      wide_digits_type p;
      logic [63:0]  prod;
      logic [63:0]  carry;
      carry = 0;
      foreach (p[i]) p[i] = '0;
      for (int i = 0; i < d; i++) begin
         prod  = 64'(modulus_q[i]) * 64'(k) + carry;
         p[i]  = prod[31:0];
         carry = {32'd0, prod[63:32]};
      end
      p[d] = carry[31:0];
      return p;
   endfunction

   function automatic wide_digits_type permuted_row(int d, int row);
      wide_digits_type t;
      int pos, e;
      foreach (t[i]) t[i] = '0;
      for (int j = 0; j < d; j++) begin
         pos = row * d + j;
         e   = (pos < IDX_D) ? int'(index_q[pos]) : 0;
         if (e >= d && e < 2 * d) t[j] = operand_q[e];
      end
      return t;
   endfunction

   // acc[0..d] +/- v[0..n-1], wrapping at the accumulator width
   task automatic acc_update(wide_digits_type v, int n, int d, bit subtract);
      logic [32:0] r;
      logic        c;
      logic [31:0] x;
      c = 0;
      for (int i = 0; i <= d; i++) begin
         x = (i < n) ? v[i] : '0;
         r = subtract ? ({1'b0, acc[i]} - {1'b0, x} - c) : ({1'b0, acc[i]} + x + c);
         acc[i] = r[31:0];
         c = r[32];
      end
   endtask

   task automatic predict_reduce();
      int              d, cmp;
      wide_digits_type t;
      logic [31:0]     trial [MAX_D+1];
      logic [32:0]     r;
      logic            c;
      rsp_item_type    item;
      d = int'(digit_count);
      if (d < D_LOW) d = D_LOW;
      if (d > MAX_D) d = MAX_D;
      cmp = 0;
      for (int i = 2 * d - 1; i >= 0 && cmp == 0; i--) begin
         if (operand_q[i] > square_q[i]) cmp = 1;
         else if (operand_q[i] < square_q[i]) cmp = -1;
      end
      if (cmp >= 0) begin
         item = '{digit: '0, pos: '0, status: 1'b1, last: 1'b1};
         expected_digits.push_back(item);
         return;
      end
      for (int i = 0; i < d; i++) acc[i] = operand_q[i];
      acc[d] = '0;
      if (sub_rows != 0) acc_update(modulus_times(d, 32'(sub_rows)), d + 1, d, 1'b0);
      for (int i = 0; i < int'(add_rows); i++)
         acc_update(permuted_row(d, i), d, d, 1'b0);
      for (int i = 0; i < int'(sub_rows); i++)
         acc_update(permuted_row(d, int'(add_rows) + i), d, d, 1'b1);
      acc_update(modulus_times(d, acc[d]), d + 1, d, 1'b1);
      acc[d] = '0;
      c = 0;
      for (int i = 0; i <= d; i++) begin
         r = {1'b0, acc[i]} - {1'b0, (i < d) ? modulus_q[i] : 32'd0} - c;
         trial[i] = r[31:0];
         c = r[32];
      end
      for (int j = 0; j < d; j++) begin
         if (!c) acc[j] = trial[j];
         item = '{digit: acc[j], pos: POS_BITS'(j), status: 1'b0, last: (j == d - 1)};
         expected_digits.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         digit_count = 5'd8;
         add_rows    = '0;
         sub_rows    = '0;
         foreach (acc[i]) acc[i] = '0;
         expected_digits.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_data.index)
               REG_DIGIT_COUNT: digit_count = csr_data.value[CNT_BITS-1:0];
               REG_ADD_ROWS:    add_rows    = csr_data.value[ROWS_BITS-1:0];
               REG_SUB_ROWS:    sub_rows    = csr_data.value[ROWS_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_data.op)
               OP_MOD:    if (req_data.slot < MAX_D) modulus_q[req_data.slot] = req_data.word;
               OP_SQR:    if (req_data.slot < SQ_D)  square_q[req_data.slot]  = req_data.word;
               OP_INDEX:  index_q[req_data.slot] = req_data.word[ENTRY_BITS-1:0];
               OP_OPND:   if (req_data.slot < SQ_D)  operand_q[req_data.slot] = req_data.word;
               OP_REDUCE: predict_reduce();
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_digits.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               fail_count++;
            end else begin
               rsp_item_type want;
               want = expected_digits.pop_front();
               if (rsp_data.digit !== want.digit) begin
                  $display("%0t: result_digit expected %h actual %h", $time, want.digit,
                           rsp_data.digit);
                  fail_count++;
               end
               if (rsp_data.pos !== want.pos) begin
                  $display("%0t: digit_position expected %0d actual %0d", $time, want.pos,
                           rsp_data.pos);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %b actual %b", $time, want.status,
                           rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_digits.size();
   end

endmodule

>>> dv/generalized_mersenne_reduction_tb.sv
// ----------------------------------------------------------------------------
// generalized_mersenne_reduction_tb: top of the reducer testbench
// Loads all stores that a reduce can read, then runs phases of register
// settings (digit count at its extremes, saturating counts too, and a range
// of row counts), each a short directed or random mix of loads, reduces and
// ignored requests, with random gaps on both sides in all but one phase. A scoreboard checks
// every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module generalized_mersenne_reduction_tb;
   import gmr_pkg::*;
   import gmr_tb_pkg::*;

   localparam int HANG_LIMIT = 200000;
   // rows * digits stays at or below this in every phase
   localparam int INDEX_FILL = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, quiet_cycles;
   bit   sender_calm, receiver_calm;
   int   cur_d, cur_rows;

   always #6 clock = ~clock;

   gmr_if #(.payload_type(req_item_type)) req_ch ();
   gmr_if #(.payload_type(rsp_item_type)) rsp_ch ();
   gmr_if #(.payload_type(csr_item_type)) csr_ch ();

   generalized_mersenne_reduction DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_ch.valid),
      .req_ready          (req_ch.ready),
      .req_op             (req_ch.data.op),
      .req_slot           (req_ch.data.slot),
      .req_word           (req_ch.data.word),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_result_digit   (rsp_ch.data.digit),
      .rsp_digit_position (rsp_ch.data.pos),
      .rsp_status         (rsp_ch.data.status),
      .rsp_last           (rsp_ch.data.last),
      .csr_valid          (csr_ch.valid),
      .csr_ready          (csr_ch.ready),
      .csr_index          (csr_ch.data.index),
      .csr_data           (csr_ch.data.value)
   );

   gmr_scoreboard residue_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_data   (req_ch.data),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_data   (rsp_ch.data),
      .csr_valid  (csr_ch.valid),
      .csr_ready  (csr_ch.ready),
      .csr_data   (csr_ch.data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= receiver_calm || ($urandom_range(99) >= 33);
      end
   end

   // hang detector: no handshake of any kind for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(op_type op, int slot, logic [31:0] word);
      while (!sender_calm && $urandom_range(99) < 33) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data.op   <= op;
      req_ch.data.slot <= SLOT_BITS'(slot);
      req_ch.data.word <= word;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      // let a request taken just now be counted in pending before checking it
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] value);
      csr_ch.valid       <= 1'b1;
      csr_ch.data.index  <= idx;
      csr_ch.data.value  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(int dc, int adds, int subs);
      drain_responses();
      write_reg(REG_DIGIT_COUNT, 32'(dc));
      write_reg(REG_ADD_ROWS, 32'(adds));
      write_reg(REG_SUB_ROWS, 32'(subs));
      cur_d    = (dc < D_LOW) ? D_LOW : (dc > MAX_D) ? MAX_D : dc;
      cur_rows = adds + subs;
   endtask

   function automatic logic [31:0] pick_digit();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_entry();
      int r, e;
      r = $urandom_range(9);
      if (r < 6)      e = cur_d + $urandom_range(cur_d - 1);
      else if (r < 8) e = 0;
      else            e = $urandom_range(31);
      return {27'($urandom), 5'(e)};
   endfunction

   task automatic random_request();
      int r, top;
      r = $urandom_range(99);
      if (r < 40) begin
         send_request(OP_OPND, ($urandom_range(9) < 9) ? $urandom_range(2 * cur_d - 1)
                                                       : $urandom_range(255), pick_digit());
      end else if (r < 55) begin
         top = cur_rows * cur_d + 3;
         if (top > 255) top = 255;
         send_request(OP_INDEX, $urandom_range(top), pick_entry());
      end else if (r < 60) begin
         send_request(OP_MOD, $urandom_range(31), pick_digit());
      end else if (r < 64) begin
         send_request(OP_SQR, $urandom_range(63),
                      ($urandom_range(3) == 0) ? pick_digit() : ($urandom | 32'hc000_0000));
      end else if (r < 95) begin
         send_request(OP_REDUCE, $urandom_range(255), $urandom);
      end else begin
         send_request(op_type'($urandom_range(FIRST_BAD_OP, LAST_BAD_OP)),
                      $urandom_range(255), $urandom);
      end
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) drain_responses();
         random_request();
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = '0;
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
      cur_d    = 8;
      cur_rows = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every store entry that a reduce of any phase below can read
      sender_calm = 1'b1;
      for (int i = 0; i < MAX_D; i++) send_request(OP_MOD, i, $urandom);
      for (int i = 0; i < SQ_D; i++) send_request(OP_SQR, i, $urandom | 32'h8000_0000);
      for (int i = 0; i < SQ_D; i++) send_request(OP_OPND, i, $urandom);
      for (int i = 0; i < INDEX_FILL; i++) send_request(OP_INDEX, i, pick_entry());
      sender_calm = 1'b0;

      // reset register values, directed corner requests
      send_request(OP_REDUCE, 0, 0);
      for (int op = FIRST_BAD_OP; op <= LAST_BAD_OP; op++)
         send_request(op_type'(op), $urandom_range(255), '1);
      send_request(OP_MOD, 16, '1);
      send_request(OP_SQR, 255, '0);
      send_request(OP_OPND, 32, '1);
      send_request(OP_INDEX, 255, 32'hffff_ffe8);
      send_request(OP_OPND, 15, '1);
      send_request(OP_SQR, 15, '0);
      send_request(OP_REDUCE, 0, 0);
      send_request(OP_SQR, 15, '1);
      send_request(OP_OPND, 15, '0);
      send_request(OP_OPND, 0, '1);
      send_request(OP_REDUCE, 0, 0);

      configure(3, 2, 1);
      // operand equal to the square is rejected too
      for (int i = 0; i < 6; i++) begin
         send_request(OP_SQR, i, '1);
         send_request(OP_OPND, i, '1);
      end
      send_request(OP_REDUCE, 0, 0);
      send_request(OP_OPND, 5, 32'hffff_fffe);
      send_request(OP_REDUCE, 0, 0);
      random_phase(12);

      configure(16, 2, 2);
      sender_calm   = 1'b1;
      receiver_calm = 1'b1;
      random_phase(14);
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;

      configure(0, 11, 10);
      random_phase(12);
      configure(31, 2, 2);
      random_phase(12);
      configure(12, 0, 0);
      random_phase(12);
      configure(5, 0, 12);
      random_phase(12);
      configure(16, 4, 0);
      random_phase(12);

      drain_responses();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
